[rtl/fwbc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fwbc_pkg;

  localparam int SLOTS_DEF      = 32;
  localparam int INDEX_BITS_DEF = 20;
  localparam int BLOCK_W        = 20;
  localparam int SLOT_W         = 5;
  localparam int STAMP_W        = 32;

  localparam logic [1:0] CMD_READ   = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_COMMIT = 2'd2;

  localparam logic [1:0] ACT_HIT  = 2'd0;
  localparam logic [1:0] ACT_LOAD = 2'd1;
  localparam logic [1:0] ACT_WB   = 2'd2;
  localparam logic [1:0] ACT_META = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_READ,
    ST_EVAL,
    ST_META,
    ST_LOAD
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_SCAN,
    OP_PICK,
    OP_READ,
    OP_EVAL,
    OP_META,
    OP_LOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_ctl_t;

  typedef struct packed {
    logic is_commit;
    logic found;
    logic vic_dirty;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

[rtl/fifo_writeback_block_cache.sv]
// Directory of a fully associative write-back block cache with FIFO replacement.
// Input channel in_*: one item is a read access, a write access or a commit.
// Result channel out_*: each item yields one or more results; out_last marks
// the final one. An unused command code is taken and yields no result.
// Tags are compared against all slots at once; the first match in ring order
// from the victim pointer is chosen, then the slot's stamp is read from a
// single-port stamp memory with a registered read.
// A hit yields one result. A miss on a clean victim yields a load; a miss on a
// dirty victim yields a write-back, a metadata result and a load. A commit
// yields one write-back for each dirty slot, one write-back per scan of the
// dirty bits, and then a metadata result as the final one.
// One item is processed at a time; in_stall is low only while idle, but a new
// item is taken while the last result still waits in the output register.
// When out_stall is high, the result is held and the controller waits before
// producing the next one. Reset empties the output register and leaves every
// slot holding block 0, clean, with a zero stamp, and the victim pointer at 0.
`timescale 1ns / 1ps
`default_nettype none

module fifo_writeback_block_cache
  import fwbc_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_cmd,
  input  wire logic [BLOCK_W-1:0] in_block_index,
  input  wire logic [STAMP_W-1:0] in_meta_seconds,
  input  wire logic [STAMP_W-1:0] in_meta_count,
  input  wire logic [STAMP_W-1:0] in_now_seconds,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_action,
  output logic [SLOT_W-1:0]       out_slot,
  output logic [BLOCK_W-1:0]      out_target_block,
  output logic [STAMP_W-1:0]      out_stamp_seconds,
  output logic [STAMP_W-1:0]      out_stamp_count,
  output logic                    out_last
);

  dp_ctl_t ctl;
  dp_sts_t sts;

  fwbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  fwbc_dpath #(
    .SLOTS      (SLOTS),
    .INDEX_BITS (INDEX_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .sts               (sts),
    .in_cmd            (in_cmd),
    .in_block_index    (in_block_index),
    .in_meta_seconds   (in_meta_seconds),
    .in_meta_count     (in_meta_count),
    .in_now_seconds    (in_now_seconds),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_action        (out_action),
    .out_slot          (out_slot),
    .out_target_block  (out_target_block),
    .out_stamp_seconds (out_stamp_seconds),
    .out_stamp_count   (out_stamp_count),
    .out_last          (out_last)
  );

  a_commit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_cmd == CMD_COMMIT |=> in_stall)
    else $error("Commit item did not start processing.");

  a_unused_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_cmd != CMD_READ && in_cmd != CMD_WRITE &&
    in_cmd != CMD_COMMIT |=> !in_stall)
    else $error("Unused command did not return to idle.");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_EVAL || ctl.op == OP_META || ctl.op == OP_LOAD) |-> sts.out_free)
    else $error("Result produced while the output register was occupied.");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && out_last && !(ctl.op == OP_EVAL && sts.is_commit) |-> !in_stall)
    else $error("Final result produced but controller not idle.");

endmodule

`default_nettype wire

[rtl/fwbc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module fwbc_ctrl
  import fwbc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_cmd,
  output logic            in_stall,
  input  wire dp_sts_t    sts,
  output dp_ctl_t         ctl
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_cmd == CMD_READ || in_cmd == CMD_WRITE ||
                         in_cmd == CMD_COMMIT)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: state_nxt = ST_PICK;
      ST_PICK: state_nxt = ST_READ;
      ST_READ: begin
        state_nxt = (sts.is_commit && !sts.found) ? ST_META : ST_EVAL;
      end
      ST_EVAL: begin
        if (sts.out_free) begin
          if (sts.is_commit) begin
            state_nxt = ST_SCAN;
          end else if (sts.found) begin
            state_nxt = ST_IDLE;
          end else if (sts.vic_dirty) begin
            state_nxt = ST_META;
          end else begin
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_META: begin
        if (sts.out_free) begin
          state_nxt = sts.is_commit ? ST_IDLE : ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.op   = OP_NONE;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.op = OP_CAPTURE;
        end
      end
      ST_SCAN: ctl.op = OP_SCAN;
      ST_PICK: ctl.op = OP_PICK;
      ST_READ: ctl.op = OP_READ;
      ST_EVAL: ctl.op = sts.out_free ? OP_EVAL : OP_NONE;
      ST_META: ctl.op = sts.out_free ? OP_META : OP_NONE;
      ST_LOAD: ctl.op = sts.out_free ? OP_LOAD : OP_NONE;
      default: ctl.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

[rtl/fwbc_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none

module fwbc_dpath
  import fwbc_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dp_ctl_t            ctl,
  output dp_sts_t                 sts,
  input  wire logic [1:0]         in_cmd,
  input  wire logic [BLOCK_W-1:0] in_block_index,
  input  wire logic [STAMP_W-1:0] in_meta_seconds,
  input  wire logic [STAMP_W-1:0] in_meta_count,
  input  wire logic [STAMP_W-1:0] in_now_seconds,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_action,
  output logic [SLOT_W-1:0]       out_slot,
  output logic [BLOCK_W-1:0]      out_target_block,
  output logic [STAMP_W-1:0]      out_stamp_seconds,
  output logic [STAMP_W-1:0]      out_stamp_count,
  output logic                    out_last
);

  localparam int PTR_W = $clog2(SLOTS);
  localparam int TAG_W = (INDEX_BITS < BLOCK_W) ? INDEX_BITS : BLOCK_W;

  logic [1:0]           cmd_r;
  logic [TAG_W-1:0]     idx_r;
  logic [STAMP_W-1:0]   ms_r;
  logic [STAMP_W-1:0]   mc_r;
  logic [STAMP_W-1:0]   now_r;

  logic [TAG_W-1:0]     tag_r [SLOTS];
  logic [SLOTS-1:0]     dirty_r;
  logic [SLOTS-1:0]     val_r;
  logic [2*STAMP_W-1:0] stamp_mem [SLOTS];
  logic [2*STAMP_W-1:0] rd_r;
  logic                 rd_val_r;

  logic [SLOTS-1:0]     vec_r;
  logic [PTR_W-1:0]     sel_r;
  logic                 found_r;
  logic [PTR_W-1:0]     vp_r;
  logic [STAMP_W-1:0]   meta_s_r;
  logic [STAMP_W-1:0]   meta_c_r;

  logic                 out_valid_r;
  logic [1:0]           out_action_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic [BLOCK_W-1:0]   out_block_r;
  logic [STAMP_W-1:0]   out_s_r;
  logic [STAMP_W-1:0]   out_c_r;
  logic                 out_last_r;

  logic [SLOTS-1:0]     match_vec;
  logic                 lo_hit;
  logic                 hi_hit;
  logic [PTR_W-1:0]     lo_idx;
  logic [PTR_W-1:0]     hi_idx;
  logic [PTR_W-1:0]     pick_idx;

  logic [STAMP_W-1:0]   rd_s;
  logic [STAMP_W-1:0]   rd_c;
  logic                 stale;
  logic [STAMP_W-1:0]   wb_c;
  logic [STAMP_W-1:0]   meta_nc;
  logic                 is_write;
  logic                 is_commit;
  logic                 out_free;

  logic                 emit;
  logic [1:0]           e_act;
  logic [SLOT_W-1:0]    e_slot;
  logic [BLOCK_W-1:0]   e_blk;
  logic [STAMP_W-1:0]   e_s;
  logic [STAMP_W-1:0]   e_c;
  logic                 e_last;
  logic                 mem_we;
  logic [2*STAMP_W-1:0] mem_wd;
  logic                 dirty_we;
  logic                 dirty_wv;
  logic                 tag_we;
  logic                 vp_adv;
  logic                 meta_we;

  assign is_write  = (cmd_r == CMD_WRITE);
  assign is_commit = (cmd_r == CMD_COMMIT);
  assign out_free  = !out_valid_r || !out_stall;

  assign sts.is_commit = is_commit;
  assign sts.found     = found_r;
  assign sts.vic_dirty = dirty_r[sel_r];
  assign sts.out_free  = out_free;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match_vec[i] = (tag_r[i] == idx_r);
    end
  end

  // First set bit in ring order, starting at the victim pointer.
  always_comb begin
    lo_hit = 1'b0;
    hi_hit = 1'b0;
    lo_idx = '0;
    hi_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (vec_r[i]) begin
        lo_hit = 1'b1;
        lo_idx = PTR_W'(i);
        if (PTR_W'(i) >= vp_r) begin
          hi_hit = 1'b1;
          hi_idx = PTR_W'(i);
        end
      end
    end
    pick_idx = hi_hit ? hi_idx : lo_idx;
  end

  assign rd_s    = rd_val_r ? rd_r[2*STAMP_W-1:STAMP_W] : '0;
  assign rd_c    = rd_val_r ? rd_r[STAMP_W-1:0] : '0;
  assign stale   = {ms_r, mc_r} > {rd_s, rd_c};
  assign wb_c    = (now_r == rd_s) ? rd_c + STAMP_W'(1) : '0;
  assign meta_nc = (now_r == meta_s_r) ? meta_c_r + STAMP_W'(1) : '0;

  always_comb begin
    emit     = 1'b0;
    e_act    = ACT_HIT;
    e_slot   = SLOT_W'(sel_r);
    e_blk    = BLOCK_W'(tag_r[sel_r]);
    e_s      = rd_s;
    e_c      = rd_c;
    e_last   = 1'b1;
    mem_we   = 1'b0;
    mem_wd   = {ms_r, mc_r};
    dirty_we = 1'b0;
    dirty_wv = is_write;
    tag_we   = 1'b0;
    vp_adv   = 1'b0;
    meta_we  = 1'b0;
    case (ctl.op)
      OP_EVAL: begin
        if (is_commit || (!found_r && dirty_r[sel_r])) begin
          emit     = 1'b1;
          e_act    = ACT_WB;
          e_s      = now_r;
          e_c      = wb_c;
          e_last   = 1'b0;
          mem_we   = 1'b1;
          mem_wd   = {now_r, wb_c};
          dirty_we = 1'b1;
          dirty_wv = 1'b0;
        end else if (found_r) begin
          emit = 1'b1;
          if (stale) begin
            e_act    = ACT_LOAD;
            e_blk    = BLOCK_W'(idx_r);
            e_s      = ms_r;
            e_c      = mc_r;
            mem_we   = 1'b1;
            dirty_we = 1'b1;
          end else begin
            dirty_we = is_write;
            dirty_wv = 1'b1;
          end
        end
      end
      OP_META: begin
        emit    = 1'b1;
        e_act   = ACT_META;
        e_slot  = '0;
        e_blk   = '0;
        e_s     = now_r;
        e_c     = meta_nc;
        e_last  = is_commit;
        meta_we = 1'b1;
      end
      OP_LOAD: begin
        emit     = 1'b1;
        e_act    = ACT_LOAD;
        e_blk    = BLOCK_W'(idx_r);
        e_s      = ms_r;
        e_c      = mc_r;
        mem_we   = 1'b1;
        dirty_we = 1'b1;
        tag_we   = 1'b1;
        vp_adv   = 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_CAPTURE) begin
      cmd_r <= in_cmd;
      idx_r <= TAG_W'(in_block_index);
      ms_r  <= in_meta_seconds;
      mc_r  <= in_meta_count;
      now_r <= in_now_seconds;
    end
    if (ctl.op == OP_SCAN) begin
      vec_r <= is_commit ? dirty_r : match_vec;
    end
    if (ctl.op == OP_PICK) begin
      found_r <= lo_hit;
      sel_r   <= lo_hit ? pick_idx : vp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_READ) begin
      rd_r     <= stamp_mem[sel_r];
      rd_val_r <= val_r[sel_r];
    end
    if (mem_we) begin
      stamp_mem[sel_r] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        tag_r[i] <= '0;
      end
      dirty_r  <= '0;
      val_r    <= '0;
      vp_r     <= '0;
      meta_s_r <= '0;
      meta_c_r <= '0;
    end else begin
      if (tag_we) begin
        tag_r[sel_r] <= idx_r;
      end
      if (dirty_we) begin
        dirty_r[sel_r] <= dirty_wv;
      end
      if (mem_we) begin
        val_r[sel_r] <= 1'b1;
      end
      if (vp_adv) begin
        vp_r <= (vp_r == PTR_W'(SLOTS - 1)) ? '0 : vp_r + PTR_W'(1);
      end
      if (meta_we) begin
        meta_s_r <= now_r;
        meta_c_r <= meta_nc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_action_r <= e_act;
      out_slot_r   <= e_slot;
      out_block_r  <= e_blk;
      out_s_r      <= e_s;
      out_c_r      <= e_c;
      out_last_r   <= e_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_action        = out_action_r;
  assign out_slot          = out_slot_r;
  assign out_target_block  = out_block_r;
  assign out_stamp_seconds = out_s_r;
  assign out_stamp_count   = out_c_r;
  assign out_last          = out_last_r;

endmodule

`default_nettype wire
